>>> sv/wapt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the watched address presence tracker.
// Used by the slot unit, the top level and the checker; depends on nothing.
package wapt_pkg;

    localparam int ADDR_W      = 48;
    localparam int SLOT_W      = 4;
    localparam int IN_DATA_W   = 120;
    localparam int OUT_DATA_W  = 208;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;
    localparam int MIN_LEN     = 24;
    localparam int OUT_PRESENT_BIT = 52;

    localparam logic [2:0] OP_FRAME  = 3'd0;
    localparam logic [2:0] OP_SWEEP  = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    localparam logic [2:0] EV_ENTERED   = 3'd0;
    localparam logic [2:0] EV_LEFT      = 3'd1;
    localparam logic [2:0] EV_OK        = 3'd2;
    localparam logic [2:0] EV_DUPLICATE = 3'd3;
    localparam logic [2:0] EV_FULL      = 3'd4;
    localparam logic [2:0] EV_NOT_FOUND = 3'd5;
    localparam logic [2:0] EV_ENTRY     = 3'd6;
    localparam logic [2:0] EV_EMPTY     = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACKING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONT     = 3'd4;

    localparam logic [1:0] FTYPE_CONTROL = 2'd1;

    typedef struct packed {
        logic        tracking;
        logic [19:0] timeout;
        logic [7:0]  min_hits;
        logic [15:0] window;
        logic [15:0] cont;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic signed [7:0] last_sig;
        logic signed [10:0] avg;
        logic [31:0]       last_seen;
        logic [31:0]       hits;
        logic [7:0]        pend_cnt;
        logic [31:0]       pend_start;
    } slot_word_t;

    typedef struct packed {
        logic        match;
        logic        stale;
        logic        entered;
        logic        present;
        logic [31:0] gap;
        slot_word_t  frame_word;
        slot_word_t  sweep_word;
    } slot_eval_t;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic              present;
        logic signed [7:0] rssi;
        logic signed [7:0] avg;
        logic [3:0]        chan;
        logic [31:0]       ts;
        logic [31:0]       absent;
        logic [31:0]       hits;
        logic [31:0]       frames;
    } res_t;

endpackage

>>> sv/wapt_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
// Holds the per-slot payload; depends on nothing.
module wapt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/wapt_slot_unit.sv
`timescale 1ns / 1ps
// Shared evaluation unit: address compare, frame update and staleness check of one slot.
// Depends on wapt_pkg.
module wapt_slot_unit (
    input  wapt_pkg::slot_word_t word,
    input  logic                 used,
    input  logic                 present,
    input  logic                 seeded,
    input  logic [47:0]          in_addr,
    input  logic signed [7:0]    in_rssi,
    input  logic [31:0]          in_now,
    input  wapt_pkg::cfg_t       cfg,
    output wapt_pkg::slot_eval_t ev
);

    logic signed [14:0] avg_w;
    logic signed [14:0] rssi_w;
    logic signed [14:0] num;
    logic signed [14:0] biased;
    logic signed [14:0] mag;
    logic signed [14:0] quot;
    logic signed [10:0] avg_new;
    logic [31:0]        dt_prev;
    logic [31:0]        dt_pend;
    logic               cont;
    logic [7:0]         pc1;
    logic [31:0]        ps1;
    logic               enter;

    always_comb begin
        avg_w  = {{4{word.avg[10]}}, word.avg};
        rssi_w = {{7{in_rssi[7]}}, in_rssi};
        num    = (avg_w <<< 3) - avg_w + (rssi_w <<< 2);
        biased = num[14] ? num - 15'sd4 : num + 15'sd4;
        mag    = biased[14] ? -biased : biased;
        quot   = biased[14] ? -(mag >>> 3) : (mag >>> 3);
        avg_new = seeded ? quot[10:0] : {rssi_w[8:0], 2'b00};

        dt_prev = in_now - word.last_seen;
        dt_pend = in_now - word.pend_start;
        cont = (word.last_seen != 32'd0) && (dt_prev <= {16'd0, cfg.cont});
        if (word.pend_cnt == 8'd0 || dt_pend > {16'd0, cfg.window}) begin
            pc1 = 8'd1;
            ps1 = in_now;
        end else begin
            pc1 = (word.pend_cnt < 8'hFF) ? word.pend_cnt + 8'd1 : word.pend_cnt;
            ps1 = word.pend_start;
        end
        enter = !present && (cont || pc1 >= cfg.min_hits);

        ev.match   = used && (word.addr == in_addr);
        ev.entered = enter;
        ev.present = present || enter;
        ev.gap     = dt_prev;
        ev.stale   = used && present && (dt_prev > {12'd0, cfg.timeout});

        ev.frame_word            = word;
        ev.frame_word.hits       = word.hits + 32'd1;
        ev.frame_word.last_seen  = in_now;
        ev.frame_word.last_sig   = in_rssi;
        ev.frame_word.avg        = avg_new;
        ev.frame_word.pend_cnt   = (present || enter) ? 8'd0 : pc1;
        ev.frame_word.pend_start = present ? word.pend_start : ps1;

        ev.sweep_word          = word;
        ev.sweep_word.pend_cnt = 8'd0;
    end

endmodule

>>> sv/watched_address_presence_tracker.sv
`timescale 1ns / 1ps
// Walk: an item walks the slot table one slot per cycle through a single RAM read port,
// except that a sweep stays on a stale slot while a result waits behind a stalled output;
// a full add or a missed remove then rereads slot 0, and a read looks up its one slot.
// Throughput: one item at a time; a new transfer is taken once the last result is queued.
// Reset: synchronous active-low aresetn empties the table, zeroes the frame counter
// and restores the register defaults; slot payload RAM is not cleared.
module watched_address_presence_tracker #(
    parameter int SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // frame_ctrl, frame_len, station_addr, signal_dbm, rx_channel, now_ms, slot_sel
    input  logic [wapt_pkg::IN_DATA_W-1:0]     s_tdata,
    // op
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // slot, addr_out, is_present, rssi_out, rssi_average, channel_out, time_out,
    // absent_for_ms, hit_count, frames_total
    output logic [wapt_pkg::OUT_DATA_W-1:0]    m_tdata,
    // event_res
    output logic [2:0]                         m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wapt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wapt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = $bits(wapt_pkg::slot_word_t);

    typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_SEL, ST_SLOT0, ST_DONE} state_t;

    state_t                     state_reg, state_next;
    wapt_pkg::cfg_t             cfg_reg, cfg_next;
    logic [31:0]                frames_reg, frames_next;
    logic [SLOTS-1:0]           used_reg, used_next;
    logic [SLOTS-1:0]           pres_reg, pres_next;
    logic [SLOTS-1:0]           seed_reg, seed_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [wapt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       free_found_reg, free_found_next;
    logic [IW-1:0]              free_idx_reg, free_idx_next;
    logic [2:0]                 slot0_ev_reg, slot0_ev_next;
    logic                       pend_valid_reg, pend_valid_next;
    wapt_pkg::res_t             pend_reg, pend_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_last_reg, out_last_next;
    wapt_pkg::res_t             out_reg, out_next;
    logic [2:0]                 op_reg, op_next;
    logic [47:0]                addr_reg, addr_next;
    logic signed [7:0]          rssi_reg, rssi_next;
    logic [3:0]                 ch_reg, ch_next;
    logic [31:0]                now_reg, now_next;
    logic [3:0]                 sel_reg, sel_next;

    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    wapt_pkg::slot_word_t       ram_wword;
    logic [IW-1:0]              ram_raddr;
    logic [WW-1:0]              ram_rdata;
    wapt_pkg::slot_word_t       rword;
    wapt_pkg::slot_eval_t       sev;
    wapt_pkg::slot_word_t       fresh;

    logic                       out_free;
    logic                       last_slot;
    logic                       frame_ok;
    logic                       have_free;
    logic [IW-1:0]              fidx;
    logic signed [10:0]         avg_abs;
    logic signed [10:0]         avg_q;

    assign rword = wapt_pkg::slot_word_t'(ram_rdata);

    wapt_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wword),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wapt_slot_unit u_unit (
        .word    (rword),
        .used    (used_reg[idx_reg]),
        .present (pres_reg[idx_reg]),
        .seeded  (seed_reg[idx_reg]),
        .in_addr (addr_reg),
        .in_rssi (rssi_reg),
        .in_now  (now_reg),
        .cfg     (cfg_reg),
        .ev      (sev)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_reg.event_res;
    assign m_tdata   = {7'd0, out_reg.frames, out_reg.hits, out_reg.absent, out_reg.ts,
                        out_reg.chan, out_reg.avg, out_reg.rssi, out_reg.present,
                        out_reg.addr, out_reg.slot};

    always_comb begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        frames_next     = frames_reg;
        used_next       = used_reg;
        pres_next       = pres_reg;
        seed_next       = seed_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot0_ev_next   = slot0_ev_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_next        = out_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        rssi_next       = rssi_reg;
        ch_next         = ch_reg;
        now_next        = now_reg;
        sel_next        = sel_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wword       = rword;
        ram_raddr       = idx_reg;

        out_free  = !out_valid_reg || m_tready;
        last_slot = (idx_reg == IW'(SLOTS - 1));
        frame_ok  = cfg_reg.tracking && (s_tdata[19:8] >= 12'(wapt_pkg::MIN_LEN))
                    && (s_tdata[3:2] != wapt_pkg::FTYPE_CONTROL) && !s_tdata[20 + 40];
        have_free = free_found_reg || !used_reg[idx_reg];
        fidx      = free_found_reg ? free_idx_reg : idx_reg;
        avg_abs   = rword.avg[10] ? -rword.avg : rword.avg;
        avg_q     = rword.avg[10] ? -(avg_abs >>> 2) : (avg_abs >>> 2);
        fresh          = '0;
        fresh.addr     = addr_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                wapt_pkg::CFG_TRACKING: cfg_next.tracking = cfg_data[0];
                wapt_pkg::CFG_TIMEOUT:  cfg_next.timeout  = cfg_data;
                wapt_pkg::CFG_MIN_HITS: cfg_next.min_hits = cfg_data[7:0];
                wapt_pkg::CFG_WINDOW:   cfg_next.window   = cfg_data[15:0];
                wapt_pkg::CFG_CONT:     cfg_next.cont     = cfg_data[15:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    addr_next       = s_tdata[67:20];
                    rssi_next       = s_tdata[75:68];
                    ch_next         = s_tdata[79:76];
                    now_next        = s_tdata[111:80];
                    sel_next        = s_tdata[115:112];
                    idx_next        = '0;
                    ram_raddr       = '0;
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_DONE;
                    unique case (s_tuser)
                        wapt_pkg::OP_FRAME: begin
                            if (frame_ok) begin
                                frames_next = frames_reg + 32'd1;
                                state_next  = ST_WALK;
                            end
                        end
                        wapt_pkg::OP_SWEEP: begin
                            if (cfg_reg.tracking) begin
                                state_next = ST_WALK;
                            end
                        end
                        wapt_pkg::OP_ADD, wapt_pkg::OP_REMOVE: begin
                            state_next = ST_WALK;
                        end
                        wapt_pkg::OP_CLEAR: begin
                            used_next = '0;
                            pres_next = '0;
                            seed_next = '0;
                            pend_next = '0;
                            pend_next.event_res = wapt_pkg::EV_OK;
                            pend_valid_next = 1'b1;
                        end
                        wapt_pkg::OP_READ: begin
                            if (int'(s_tdata[115:112]) < SLOTS) begin
                                ram_raddr  = IW'(s_tdata[115:112]);
                                idx_next   = IW'(s_tdata[115:112]);
                                state_next = ST_SEL;
                            end else begin
                                pend_next = '0;
                                pend_next.event_res = wapt_pkg::EV_EMPTY;
                                pend_next.slot = s_tdata[115:112];
                                pend_valid_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                unique case (op_reg)
                    wapt_pkg::OP_FRAME: begin
                        if (sev.match) begin
                            ram_we             = 1'b1;
                            ram_wword          = sev.frame_word;
                            seed_next[idx_reg] = 1'b1;
                            pres_next[idx_reg] = sev.present;
                            if (sev.entered) begin
                                pend_next           = '0;
                                pend_next.event_res = wapt_pkg::EV_ENTERED;
                                pend_next.slot      = wapt_pkg::SLOT_W'(idx_reg);
                                pend_next.addr      = rword.addr;
                                pend_next.present   = 1'b1;
                                pend_next.rssi      = rssi_reg;
                                pend_next.chan      = ch_reg;
                                pend_next.ts        = now_reg;
                                pend_next.hits      = sev.frame_word.hits;
                                pend_valid_next     = 1'b1;
                            end
                            state_next = ST_DONE;
                        end else if (last_slot) begin
                            state_next = ST_DONE;
                        end else begin
                            idx_next  = idx_reg + 1'b1;
                            ram_raddr = idx_reg + 1'b1;
                        end
                    end
                    wapt_pkg::OP_SWEEP: begin
                        if (sev.stale && pend_valid_reg && !out_free) begin
                            ram_raddr = idx_reg;
                        end else begin
                            if (sev.stale) begin
                                ram_we             = 1'b1;
                                ram_wword          = sev.sweep_word;
                                pres_next[idx_reg] = 1'b0;
                                seed_next[idx_reg] = 1'b0;
                                if (pend_valid_reg) begin
                                    out_next        = pend_reg;
                                    out_next.frames = frames_reg;
                                    out_last_next   = 1'b0;
                                    out_valid_next  = 1'b1;
                                end
                                pend_next           = '0;
                                pend_next.event_res = wapt_pkg::EV_LEFT;
                                pend_next.slot      = wapt_pkg::SLOT_W'(idx_reg);
                                pend_next.addr      = rword.addr;
                                pend_next.rssi      = rword.last_sig;
                                pend_next.ts        = now_reg;
                                pend_next.absent    = sev.gap;
                                pend_next.hits      = rword.hits;
                                pend_valid_next     = 1'b1;
                                cnt_next            = cnt_reg + 1'b1;
                            end
                            if (last_slot || (sev.stale &&
                                cnt_reg == wapt_pkg::CNT_W'(wapt_pkg::MAX_RESULTS - 1))) begin
                                state_next = ST_DONE;
                            end else begin
                                idx_next  = idx_reg + 1'b1;
                                ram_raddr = idx_reg + 1'b1;
                            end
                        end
                    end
                    wapt_pkg::OP_ADD: begin
                        if (sev.match) begin
                            pend_next           = '0;
                            pend_next.event_res = wapt_pkg::EV_DUPLICATE;
                            pend_next.slot      = wapt_pkg::SLOT_W'(idx_reg);
                            pend_next.addr      = rword.addr;
                            pend_next.present   = pres_reg[idx_reg];
                            pend_next.rssi      = rword.last_sig;
                            pend_next.hits      = rword.hits;
                            pend_valid_next     = 1'b1;
                            state_next          = ST_DONE;
                        end else if (last_slot) begin
                            if (have_free) begin
                                ram_we          = 1'b1;
                                ram_waddr       = fidx;
                                ram_wword       = fresh;
                                used_next[fidx] = 1'b1;
                                pres_next[fidx] = 1'b0;
                                seed_next[fidx] = 1'b0;
                                pend_next           = '0;
                                pend_next.event_res = wapt_pkg::EV_OK;
                                pend_next.slot      = wapt_pkg::SLOT_W'(fidx);
                                pend_next.addr      = addr_reg;
                                pend_valid_next     = 1'b1;
                                state_next          = ST_DONE;
                            end else begin
                                slot0_ev_next = wapt_pkg::EV_FULL;
                                ram_raddr     = '0;
                                state_next    = ST_SLOT0;
                            end
                        end else begin
                            if (!used_reg[idx_reg] && !free_found_reg) begin
                                free_found_next = 1'b1;
                                free_idx_next   = idx_reg;
                            end
                            idx_next  = idx_reg + 1'b1;
                            ram_raddr = idx_reg + 1'b1;
                        end
                    end
                    wapt_pkg::OP_REMOVE: begin
                        if (sev.match) begin
                            pend_next           = '0;
                            pend_next.event_res = wapt_pkg::EV_OK;
                            pend_next.slot      = wapt_pkg::SLOT_W'(idx_reg);
                            pend_next.addr      = rword.addr;
                            pend_next.present   = pres_reg[idx_reg];
                            pend_next.rssi      = rword.last_sig;
                            pend_next.hits      = rword.hits;
                            pend_valid_next     = 1'b1;
                            used_next[idx_reg]  = 1'b0;
                            state_next          = ST_DONE;
                        end else if (last_slot) begin
                            slot0_ev_next = wapt_pkg::EV_NOT_FOUND;
                            ram_raddr     = '0;
                            state_next    = ST_SLOT0;
                        end else begin
                            idx_next  = idx_reg + 1'b1;
                            ram_raddr = idx_reg + 1'b1;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SLOT0: begin
                pend_next           = '0;
                pend_next.event_res = slot0_ev_reg;
                if (used_reg[0]) begin
                    pend_next.addr    = rword.addr;
                    pend_next.present = pres_reg[0];
                    pend_next.rssi    = rword.last_sig;
                    pend_next.hits    = rword.hits;
                end
                pend_valid_next = 1'b1;
                state_next      = ST_DONE;
            end
            ST_SEL: begin
                pend_next      = '0;
                pend_next.slot = sel_reg;
                if (used_reg[idx_reg]) begin
                    pend_next.event_res = wapt_pkg::EV_ENTRY;
                    pend_next.addr      = rword.addr;
                    pend_next.present   = pres_reg[idx_reg];
                    pend_next.rssi      = rword.last_sig;
                    pend_next.avg       = avg_q[7:0];
                    pend_next.hits      = rword.hits;
                end else begin
                    pend_next.event_res = wapt_pkg::EV_EMPTY;
                end
                pend_valid_next = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_next.frames = frames_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            cfg_reg.tracking     <= 1'b0;
            cfg_reg.timeout      <= 20'd30000;
            cfg_reg.min_hits     <= 8'd2;
            cfg_reg.window       <= 16'd3000;
            cfg_reg.cont         <= 16'd5000;
            frames_reg           <= '0;
            used_reg             <= '0;
            pres_reg             <= '0;
            seed_reg             <= '0;
            pend_valid_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
        end else begin
            state_reg            <= state_next;
            cfg_reg              <= cfg_next;
            frames_reg           <= frames_next;
            used_reg             <= used_next;
            pres_reg             <= pres_next;
            seed_reg             <= seed_next;
            pend_valid_reg       <= pend_valid_next;
            out_valid_reg        <= out_valid_next;
        end
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        slot0_ev_reg   <= slot0_ev_next;
        pend_reg       <= pend_next;
        out_last_reg   <= out_last_next;
        out_reg        <= out_next;
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        rssi_reg       <= rssi_next;
        ch_reg         <= ch_next;
        now_reg        <= now_next;
        sel_reg        <= sel_next;
    end

endmodule

>>> sv/wapt_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the watched address presence tracker, bound to its top level.
// Depends on wapt_pkg and watched_address_presence_tracker.
module wapt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [wapt_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic [2:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [wapt_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [2:0]                      m_tuser,
    input logic                            m_tlast,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [wapt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [wapt_pkg::CFG_DATA_W-1:0] cfg_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result transfer changed");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while an item is in work");

    a_entered_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == wapt_pkg::EV_ENTERED |-> m_tdata[wapt_pkg::OUT_PRESENT_BIT])
        else $error("entered event without presence");

    a_left_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == wapt_pkg::EV_LEFT |-> !m_tdata[wapt_pkg::OUT_PRESENT_BIT])
        else $error("left event still present");

endmodule

bind watched_address_presence_tracker wapt_checker u_wapt_checker (.*);
